// ----- hdl/lkvc_pkg.sv -----
// Shared types and constants for the LRU key/value cache.
package lkvc_pkg;

   // Width of the capacity register and its reset value
   localparam int CAP_BITS = 5;
   localparam logic [CAP_BITS-1:0] DEFAULT_CAPACITY = 5'd10;

   // Request operation codes
   typedef enum logic {
      OP_GET = 1'b0,
      OP_ADD = 1'b1
   } op_type;

   // Control broadcast from the core to every cell of the chain
   typedef struct packed {
      logic capture;  // request beat taken: latch the key compare
      logic apply;    // update cycle: shift the chain where enabled
      logic hit;      // some cell matched the key
      logic add;      // request is an add
      logic evict;    // add of a new key drops the least recent entry
   } cell_ctrl_type;

endpackage

// ----- hdl/lkvc_cell.sv -----
// One entry of the recency-ordered chain: key, value, valid and match flag.
module lkvc_cell #(
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  lkvc_pkg::cell_ctrl_type ctrl,
   input  logic [KEY_BITS-1:0]   lookup_key,
   // entry handed over from the more recent neighbor
   input  logic                  left_valid,
   input  logic [KEY_BITS-1:0]   left_key,
   input  logic [VALUE_BITS-1:0] left_value,
   // match summary from the less recent neighbors
   input  logic                  up_hit_in,
   input  logic [VALUE_BITS-1:0] up_value_in,
   output logic                  up_hit_out,
   output logic [VALUE_BITS-1:0] up_value_out,
   // this cell's entry, seen by the less recent neighbor
   output logic                  ent_valid,
   output logic [KEY_BITS-1:0]   ent_key,
   output logic [VALUE_BITS-1:0] ent_value
);
   import lkvc_pkg::*;

   logic                  valid_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [VALUE_BITS-1:0] value_ff;
   logic                  match_ff;
   logic                  match_in;
   logic                  shift;

   // Match summary passed toward the front of the chain
   always_comb begin
      up_hit_out   = match_ff | up_hit_in;
      up_value_out = up_value_in | (match_ff ? value_ff : '0);
   end

   // A hit moves the matched entry to the front: every cell up to it shifts.
   // A new key shifts the live prefix; with eviction the last live entry drops.
   always_comb begin
      match_in = valid_ff && (key_ff == lookup_key);
      if (!ctrl.apply) begin
         shift = 1'b0;
      end else if (ctrl.hit) begin
         shift = up_hit_out;
      end else if (ctrl.add) begin
         shift = ctrl.evict ? valid_ff : left_valid;
      end else begin
         shift = 1'b0;
      end
   end

   // Control flags
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         if (shift) begin
            valid_ff <= left_valid;
         end
         if (ctrl.capture) begin
            match_ff <= match_in;
         end
      end
   end

   // Entry payload
   always_ff @(posedge clock) begin
      if (shift) begin
         key_ff   <= left_key;
         value_ff <= left_value;
      end
   end

   assign ent_valid = valid_ff;
   assign ent_key   = key_ff;
   assign ent_value = value_ff;

endmodule

// ----- hdl/lru_key_value_cache_core.sv -----
// Top level of the LRU key/value cache: request latch, control and cell chain.
//
// Usage:
//   Request channel: drive req_opcode, req_lookup_key and req_write_value with
//   start high; the beat is taken at a rising edge where busy is low.
//   Result channel: rsp_strobe is high for exactly one cycle with rsp_hit and
//   rsp_read_value; the receiver cannot stall it and must take it then.
//   Configuration: csr_write_enable with csr_write_data writes the capacity
//   register (0 means 10, values above DEPTH mean DEPTH); write only when idle.
// Request handling:
//   For each request beat, every cell registers its key compare at the
//   accepting edge; in the next cycle the match flags are combined, and the
//   edge that ends it shifts the recency chain and registers the result. The
//   result is on the ports in the cycle right after that edge; busy is high
//   for one cycle, so no new beat is taken while one is in flight.
// Entries sit in a chain ordered by recency, cell 0 the most recent; live
// entries form a prefix of the chain and the least recent one is evicted.
// Reset (synchronous) empties the chain, sets capacity to 10 and drops any
// request in flight; no clearing pass is needed.
module lru_key_value_cache_core #(
   parameter int DEPTH      = 16,
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_opcode,
   input  logic [KEY_BITS-1:0]            req_lookup_key,
   input  logic [VALUE_BITS-1:0]          req_write_value,
   // result channel
   output logic                           rsp_strobe,
   output logic                           rsp_hit,
   output logic [VALUE_BITS-1:0]          rsp_read_value,
   // configuration
   input  logic                           csr_write_enable,
   input  logic [lkvc_pkg::CAP_BITS-1:0]  csr_write_data
);
   import lkvc_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > CAP_BITS) ? CNT_W : CAP_BITS;

   logic                  busy_ff;
   op_type                op_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [VALUE_BITS-1:0] wval_ff;
   logic [CAP_BITS-1:0]   cap_ff;
   logic [CNT_W-1:0]      live_count_ff;
   logic [CNT_W-1:0]      live_count_in;
   logic                  rsp_strobe_ff;
   logic                  rsp_hit_ff;
   logic [VALUE_BITS-1:0] rsp_value_ff;
   logic [VALUE_BITS-1:0] rsp_value_in;

   logic                  accept;
   logic [CMP_W-1:0]      eff_cap;
   logic                  evict;
   logic                  hit;
   cell_ctrl_type         ctrl;
   logic [VALUE_BITS-1:0] front_value;

   // chain links
   logic                  ent_valid  [DEPTH];
   logic [KEY_BITS-1:0]   ent_key    [DEPTH];
   logic [VALUE_BITS-1:0] ent_value  [DEPTH];
   logic                  left_valid [DEPTH];
   logic [KEY_BITS-1:0]   left_key   [DEPTH];
   logic [VALUE_BITS-1:0] left_value [DEPTH];
   logic                  up_hit     [DEPTH+1];
   logic [VALUE_BITS-1:0] up_value   [DEPTH+1];

   assign accept = start && !busy_ff;
   assign hit    = up_hit[0];

   // Effective capacity and eviction decision
   always_comb begin
      eff_cap = (cap_ff == '0) ? CMP_W'(DEFAULT_CAPACITY) : CMP_W'(cap_ff);
      if (eff_cap > CMP_W'(DEPTH)) begin
         eff_cap = CMP_W'(DEPTH);
      end
      evict = CMP_W'(live_count_ff) >= eff_cap;
   end

   // Broadcast control to the cells
   always_comb begin
      ctrl.capture = accept;
      ctrl.apply   = busy_ff;
      ctrl.hit     = hit;
      ctrl.add     = (op_ff == OP_ADD);
      ctrl.evict   = evict;
   end

   // Front entry loaded into cell 0: new value on add, moved value on get hit
   assign front_value = (op_ff == OP_ADD) ? wval_ff : up_value[0];

   // Result and live count for the update cycle
   always_comb begin
      rsp_value_in  = (op_ff == OP_GET && hit) ? up_value[0] : '0;
      live_count_in = live_count_ff;
      if (busy_ff && op_ff == OP_ADD && !hit && !evict) begin
         live_count_in = live_count_ff + 1'b1;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         live_count_ff <= '0;
         cap_ff        <= DEFAULT_CAPACITY;
      end else begin
         busy_ff       <= accept;
         rsp_strobe_ff <= busy_ff;
         live_count_ff <= live_count_in;
         if (csr_write_enable) begin
            cap_ff <= csr_write_data;
         end
      end
   end

   // Request latch and result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= op_type'(req_opcode);
         key_ff  <= req_lookup_key;
         wval_ff <= req_write_value;
      end
      if (busy_ff) begin
         rsp_hit_ff   <= hit;
         rsp_value_ff <= rsp_value_in;
      end
   end

   // Recency chain
   assign up_hit[DEPTH]   = 1'b0;
   assign up_value[DEPTH] = '0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_front
         assign left_valid[i] = 1'b1;
         assign left_key[i]   = key_ff;
         assign left_value[i] = front_value;
      end else begin : g_link
         assign left_valid[i] = ent_valid[i-1];
         assign left_key[i]   = ent_key[i-1];
         assign left_value[i] = ent_value[i-1];
      end

      lkvc_cell #(
         .KEY_BITS   (KEY_BITS),
         .VALUE_BITS (VALUE_BITS)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (ctrl),
         .lookup_key   (req_lookup_key),
         .left_valid   (left_valid[i]),
         .left_key     (left_key[i]),
         .left_value   (left_value[i]),
         .up_hit_in    (up_hit[i+1]),
         .up_value_in  (up_value[i+1]),
         .up_hit_out   (up_hit[i]),
         .up_value_out (up_value[i]),
         .ent_valid    (ent_valid[i]),
         .ent_key      (ent_key[i]),
         .ent_value    (ent_value[i])
      );
   end

   assign busy           = busy_ff;
   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_read_value = rsp_value_ff;

endmodule

// ----- hdl/lkvc_checker.sv -----
// Port-level checks of the LRU key/value cache and their bind to the top level.
module lkvc_checker #(
   parameter int VALUE_BITS = 32
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input logic                  req_opcode,
   input logic                  rsp_strobe,
   input logic                  rsp_hit,
   input logic [VALUE_BITS-1:0] rsp_read_value
);
   import lkvc_pkg::*;

   // An accepted beat raises busy and so holds off the next one
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after an accepted request beat");

   // Every accepted beat gives a result strobe, registered from busy
   a_result_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_strobe)
      else $error("result strobe missing two cycles after a request beat");

   // Results never come without a request in flight
   a_no_spurious_result: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result strobe without a request in flight");

   // An add never returns data
   a_add_reads_zero: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_opcode == OP_ADD) |=> ##1 (rsp_read_value == '0))
      else $error("add returned a nonzero read value");

   // A miss returns zero
   a_miss_reads_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_hit) |-> (rsp_read_value == '0))
      else $error("miss returned a nonzero read value");

endmodule

bind lru_key_value_cache_core lkvc_checker #(
   .VALUE_BITS (VALUE_BITS)
) u_lkvc_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_opcode     (req_opcode),
   .rsp_strobe     (rsp_strobe),
   .rsp_hit        (rsp_hit),
   .rsp_read_value (rsp_read_value)
);

// ----- tb/sv/lkvc_result_checker.sv -----
// Checker for the LRU key/value cache: predicts each result beat and compares it.
module lkvc_result_checker #(
   parameter int DEPTH      = 16,
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic                          req_opcode,
   input  logic [KEY_BITS-1:0]           req_lookup_key,
   input  logic [VALUE_BITS-1:0]         req_write_value,
   input  logic                          rsp_strobe,
   input  logic                          rsp_hit,
   input  logic [VALUE_BITS-1:0]         rsp_read_value,
   input  logic                          csr_write_enable,
   input  logic [lkvc_pkg::CAP_BITS-1:0] csr_write_data,
   output int                            mismatch_total,
   output int                            pending_total
);
   timeunit 1ns;
   timeprecision 1ps;
   import lkvc_pkg::*;

   typedef struct {
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] value;
   } cache_entry_type;

   typedef struct {
      logic                  hit;
      logic [VALUE_BITS-1:0] read_value;
   } lookup_result_type;

   // Live entries in recency order: index 0 most recent, last one evicted first
   cache_entry_type   lru_entries[$];
   lookup_result_type expected_lookups[$];
   logic [CAP_BITS-1:0] capacity_reg;
   int mismatch_count;

   // Zero falls back to the default, anything past the store size is clipped
   function automatic int live_limit();
      if (capacity_reg == '0) return int'(DEFAULT_CAPACITY);
      if (int'(capacity_reg) > DEPTH) return DEPTH;
      return int'(capacity_reg);
   endfunction

   // Apply one request to the shadow cache and return what the block should answer
   function automatic lookup_result_type serve_request(input op_type op,
                                                       input logic [KEY_BITS-1:0] key,
                                                       input logic [VALUE_BITS-1:0] value);
      lookup_result_type res;
      cache_entry_type   ent;
      int                pos;
      pos = -1;
      foreach (lru_entries[i])
         if (pos < 0 && lru_entries[i].key == key) pos = i;
      res.hit        = (pos >= 0);
      res.read_value = '0;
      if (pos >= 0) begin
         ent = lru_entries[pos];
         if (op == OP_GET) res.read_value = ent.value;
         else ent.value = value;
         lru_entries.delete(pos);
         lru_entries.push_front(ent);
      end else if (op == OP_ADD) begin
         // one eviction per new key, even when capacity dropped below the count
         if (lru_entries.size() >= live_limit()) void'(lru_entries.pop_back());
         ent.key   = key;
         ent.value = value;
         lru_entries.push_front(ent);
      end
      return res;
   endfunction

   // Results are checked before a new beat is predicted at the same edge
   always @(posedge clock) begin : watch
      lookup_result_type want;
      if (reset) begin
         lru_entries.delete();
         expected_lookups.delete();
         capacity_reg = DEFAULT_CAPACITY;
      end else begin
         if (rsp_strobe) begin
            if (expected_lookups.size() == 0) begin
               $error("result beat with no request outstanding: hit %0b, read_value %h",
                      rsp_hit, rsp_read_value);
               mismatch_count++;
            end else begin
               want = expected_lookups.pop_front();
               if (rsp_hit !== want.hit) begin
                  $error("hit mismatch: expected %0b, actual %0b", want.hit, rsp_hit);
                  mismatch_count++;
               end
               if (rsp_read_value !== want.read_value) begin
                  $error("read_value mismatch: expected %h, actual %h",
                         want.read_value, rsp_read_value);
                  mismatch_count++;
               end
            end
         end
         if (csr_write_enable) capacity_reg = csr_write_data;
         if (start && !busy)
            expected_lookups.push_back(serve_request(op_type'(req_opcode),
                                                     req_lookup_key, req_write_value));
      end
      mismatch_total = mismatch_count;
      pending_total  = expected_lookups.size();
   end

endmodule

// ----- tb/sv/tb_lru_key_value_cache_core.sv -----
// Testbench top for the LRU key/value cache: stimulus, clock, reset and verdict.
module tb_lru_key_value_cache_core;
   timeunit 1ns;
   timeprecision 1ps;
   import lkvc_pkg::*;

   localparam int DEPTH         = 16;
   localparam int KEY_BITS      = 32;
   localparam int VALUE_BITS    = 32;
   localparam int PHASE_ITEMS   = 70;
   localparam int NUM_PHASES    = 10;
   localparam int CYCLE_LIMIT   = 100000;
   localparam logic [KEY_BITS-1:0]   KEY_ONES   = '1;
   localparam logic [VALUE_BITS-1:0] VALUE_ONES = '1;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic                  req_opcode;
   logic [KEY_BITS-1:0]   req_lookup_key;
   logic [VALUE_BITS-1:0] req_write_value;
   logic                  rsp_strobe;
   logic                  rsp_hit;
   logic [VALUE_BITS-1:0] rsp_read_value;
   logic                  csr_write_enable;
   logic [CAP_BITS-1:0]   csr_write_data;
   int                    mismatch_total;
   int                    pending_total;

   int                    idle_pct;
   int                    cycle_count;
   logic [KEY_BITS-1:0]   key_base;
   int                    key_span;

   lru_key_value_cache_core #(
      .DEPTH      (DEPTH),
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_opcode       (req_opcode),
      .req_lookup_key   (req_lookup_key),
      .req_write_value  (req_write_value),
      .rsp_strobe       (rsp_strobe),
      .rsp_hit          (rsp_hit),
      .rsp_read_value   (rsp_read_value),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   lkvc_result_checker #(
      .DEPTH      (DEPTH),
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) checker_i (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_opcode       (req_opcode),
      .req_lookup_key   (req_lookup_key),
      .req_write_value  (req_write_value),
      .rsp_strobe       (rsp_strobe),
      .rsp_hit          (rsp_hit),
      .rsp_read_value   (rsp_read_value),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .mismatch_total   (mismatch_total),
      .pending_total    (pending_total)
   );

   always #4 clock = ~clock;

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Random idle cycles between request beats; junk on the payload while idle
   task automatic idle_gap();
      if ($urandom_range(0, 99) < idle_pct) begin
         repeat ($urandom_range(1, 3)) begin
            @(negedge clock);
            start           <= 1'b0;
            req_opcode      <= 1'($urandom);
            req_lookup_key  <= $urandom;
            req_write_value <= $urandom;
         end
      end
   endtask

   // Present one request beat and hold it until busy is low at an edge
   task automatic send_request(input op_type op, input logic [KEY_BITS-1:0] key,
                               input logic [VALUE_BITS-1:0] value);
      @(negedge clock);
      start           <= 1'b1;
      req_opcode      <= op;
      req_lookup_key  <= key;
      req_write_value <= value;
      do @(posedge clock); while (busy);
      idle_gap();
   endtask

   // Stop requesting and wait for every outstanding result beat
   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (pending_total != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic set_capacity(input logic [CAP_BITS-1:0] cap);
      drain();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= cap;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Keys mostly from a small window so gets and adds hit live entries
   function automatic logic [KEY_BITS-1:0] pick_key();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return key_base + KEY_BITS'($urandom_range(0, key_span - 1));
      if (r < 90) return $urandom;
      if (r < 95) return '0;
      return KEY_ONES;
   endfunction

   function automatic logic [VALUE_BITS-1:0] pick_value();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return '0;
      if (r == 1) return VALUE_ONES;
      return $urandom;
   endfunction

   initial begin
      logic [CAP_BITS-1:0] phase_caps[NUM_PHASES];
      int                  eff;
      reset            = 1'b1;
      start            = 1'b0;
      req_opcode       = OP_GET;
      req_lookup_key   = '0;
      req_write_value  = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      idle_pct         = 16;
      key_base         = '0;
      key_span         = 8;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: default capacity of 10 after reset
      send_request(OP_GET, '0, '0);                   // empty cache miss
      send_request(OP_ADD, '0, '0);
      send_request(OP_ADD, KEY_ONES, VALUE_ONES);
      send_request(OP_GET, KEY_ONES, '0);
      send_request(OP_GET, '0, VALUE_ONES);           // write_value ignored on get
      send_request(OP_ADD, '0, 32'hA5A5_A5A5);        // update value, move to front
      send_request(OP_GET, '0, '0);
      send_request(OP_ADD, KEY_ONES, '0);
      // fill past capacity: last two adds evict the two oldest
      for (int k = 1; k <= 10; k++)
         send_request(OP_ADD, KEY_BITS'(k), VALUE_BITS'(k * 32'h0101_0101));
      send_request(OP_GET, '0, '0);                   // evicted
      send_request(OP_GET, KEY_BITS'(1), '0);         // refresh key 1
      send_request(OP_ADD, KEY_BITS'(11), 32'h5A5A_5A5A);
      send_request(OP_GET, KEY_BITS'(2), '0);         // evicted instead of key 1
      send_request(OP_GET, KEY_BITS'(1), '0);

      // Random phases; 16 then 3 lowers capacity below the live count
      phase_caps[0] = 5'd1;
      phase_caps[1] = 5'd16;
      phase_caps[2] = 5'd3;
      phase_caps[3] = 5'd0;
      phase_caps[4] = 5'd31;
      phase_caps[5] = 5'd17;
      phase_caps[6] = 5'd2;
      phase_caps[7] = 5'($urandom_range(1, 16));
      phase_caps[8] = 5'($urandom);
      phase_caps[9] = 5'd16;
      for (int p = 0; p < NUM_PHASES; p++) begin
         set_capacity(phase_caps[p]);
         eff = (phase_caps[p] == 0) ? int'(DEFAULT_CAPACITY)
             : (int'(phase_caps[p]) > DEPTH) ? DEPTH : int'(phase_caps[p]);
         key_span = eff + 3;
         // phase 2 inherits a full cache from phase 1, so keep its keys
         if (p != 2) key_base = $urandom;
         idle_pct = (p == 4) ? 0 : 16;
         for (int n = 0; n < PHASE_ITEMS; n++)
            send_request(op_type'($urandom_range(0, 1)), pick_key(), pick_value());
      end

      drain();
      if (mismatch_total == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// ----- files.f -----
hdl/lkvc_pkg.sv
hdl/lkvc_cell.sv
hdl/lru_key_value_cache_core.sv
hdl/lkvc_checker.sv
tb/sv/lkvc_result_checker.sv
tb/sv/tb_lru_key_value_cache_core.sv
